### rtl/bmm_pkg.sv
// Shared types and constants for the binary mask morphology cleanup unit.
package bmm_pkg;

   // Request and response payloads
   typedef struct packed {
      logic mask_bit;
      logic frame_start;
   } req_payload_type;

   typedef struct packed {
      logic clean_bit;
      logic frame_last;
   } rsp_payload_type;

   // Register map
   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   localparam int PADDR_W      = 3;
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 12;
   localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;
   localparam int MIN_WIDTH    = 33;

   // Structuring element radii: the closing and the opening erosion share one radius
   localparam int SQ_RADIUS     = 2;
   localparam int DILATE_RADIUS = 30;
   localparam int SQ_ROWS       = 2 * SQ_RADIUS;
   localparam int DIL_ROWS      = 2 * DILATE_RADIUS;
   localparam int CLOSED_DELAY  = DILATE_RADIUS + SQ_RADIUS - 2 * SQ_RADIUS;

   // Position counters
   localparam int ROW_W  = 13;
   localparam int SROW_W = ROW_W + 2;
   localparam logic [ROW_W-1:0] ROW_MAX = 13'd8191;

   // True when a signed row index lies inside the frame
   function automatic logic row_in_frame(input logic signed [SROW_W-1:0] row,
                                         input logic signed [SROW_W-1:0] height);
      return (row >= 0) && (row < height);
   endfunction

endpackage

### rtl/bmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmm_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/bmm_cell.sv
// One tap cell of a horizontal window line: holds a pixel and masks it.
module bmm_cell #(
   parameter bit TAKE_MIN = 1'b0
) (
   input  logic clock,
   input  logic shift_en,
   input  logic din,
   input  logic keep,
   output logic q,
   output logic term
);

   logic q_ff;

   // Take the neighbor's pixel on every processed request
   always_ff @(posedge clock) begin
      if (shift_en) begin
         q_ff <= din;
      end
   end

   assign q = q_ff;

   // Out-of-row pixels are neutral: 1 for erosion, 0 for dilation
   assign term = TAKE_MIN ? (q_ff | ~keep) : (q_ff & keep);

endmodule

### rtl/bmm_line.sv
// Horizontal window along one image row, built as a chain of tap cells.
module bmm_line #(
   parameter int RADIUS   = 2,
   parameter bit TAKE_MIN = 1'b0,
   parameter int COL_W    = 10,
   parameter int WID_W    = 11
) (
   input  logic             clock,
   input  logic             shift_en,
   input  logic             din,
   input  logic [COL_W-1:0] col,
   input  logic [WID_W-1:0] frame_w,
   output logic             dout
);

   localparam int TAPS  = 2 * RADIUS + 1;
   localparam int CMP_W = WID_W + 1;

   logic [TAPS-1:0] tap;
   logic [TAPS-1:0] keep;
   logic [TAPS-1:0] term;
   logic [CMP_W-1:0] col_x;
   logic [CMP_W-1:0] lim_x;

   assign col_x = CMP_W'(col);
   assign lim_x = CMP_W'(col) + CMP_W'(frame_w);

   // Keep taps in the window center's row: the current row once the center
   // has a full left side, else the previous row
   always_comb begin
      for (int j = 0; j < TAPS; j++) begin
         if (col_x >= CMP_W'(RADIUS)) begin
            keep[j] = (CMP_W'(j) <= col_x);
         end else begin
            keep[j] = (CMP_W'(j) > col_x) && (CMP_W'(j) <= lim_x);
         end
      end
   end

   // Newest pixel enters the window directly
   assign tap[0]  = din;
   assign term[0] = TAKE_MIN ? (din | ~keep[0]) : (din & keep[0]);

   for (genvar k = 1; k < TAPS; k++) begin : g_cell
      bmm_cell #(.TAKE_MIN(TAKE_MIN)) u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .din      (tap[k-1]),
         .keep     (keep[k]),
         .q        (tap[k]),
         .term     (term[k])
      );
   end

   assign dout = TAKE_MIN ? (&term) : (|term);

endmodule

### rtl/binary_mask_morphology_cleanup_unit.sv
// Top level: mask cleanup by 5x5 closing ANDed with a 5x5 erosion and 61x61 dilation.
// Throughput: one request per cycle unless output stalls, one result per request in frame.
// The result for pixel k leaves the output register after the request at position
//   k + 32*(width+1) is accepted (a registered RAM read, then one output stage).
// Reset: position counters and valid flags clear, frame size returns to 640x480; the row
//   RAMs are not cleared, out-of-frame rows are masked by position instead.
module binary_mask_morphology_cleanup_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  bmm_pkg::req_payload_type       req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bmm_pkg::rsp_payload_type       rsp_payload,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bmm_pkg::PADDR_W-1:0]    paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   import bmm_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = COL_W + 1;
   localparam int CMP_W = WID_W + 1;
   localparam int EXT_W = 13;

   // Configuration registers
   logic [CFG_WIDTH_W-1:0]  width_ff, width_in;
   logic [CFG_HEIGHT_W-1:0] height_ff, height_in;
   logic                    cfg_write;
   reg_index_type           cfg_index;
   logic [EXT_W-1:0]        width_ext;
   logic [WID_W-1:0]        eff_w;
   logic [CFG_HEIGHT_W-1:0] eff_h;

   // Position and stage registers
   logic [ROW_W-1:0] row_ff, row_in, cur_row;
   logic [COL_W-1:0] col_ff, col_in, cur_col;
   logic             b_valid_ff, b_valid_in;
   logic             b_bit_ff;
   logic [ROW_W-1:0] b_row_ff;
   logic [COL_W-1:0] b_col_ff;
   logic             accept;
   logic             fire_b;

   // Row RAM data
   logic [SQ_ROWS-1:0]      rd_in_rows, wr_in_rows;
   logic [SQ_ROWS-1:0]      rd_dil_rows, wr_dil_rows;
   logic [DIL_ROWS-1:0]     rd_max_rows, wr_max_rows;
   logic [CLOSED_DELAY-1:0] rd_cls_rows, wr_cls_rows;
   logic [CLOSED_DELAY-1:0] cls_dly_ff;

   // Datapath
   logic signed [SROW_W-1:0] r0_s, r1_s, r3_s, r4_s, h_s, rk_s;
   logic [CMP_W-1:0]         c0_x, c1_x, c3_x, w_x;
   logic [COL_W-1:0]         c1;
   logic                     c0_lt, c1_lt;
   logic                     v1_or, v1_and, v2_and, v4_or;
   logic                     dil1, ero1, closed, row_max;
   logic                     res_valid, res_last, res_bit;

   rsp_payload_type rsp_payload_ff;
   logic            rsp_valid_ff;

   // Register port: writes on the access phase
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign cfg_index = reg_index_type'(paddr[2]);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      prdata    = '0;
      unique case (cfg_index)
         REG_FRAME_WIDTH: begin
            prdata = 32'(width_ff);
            if (cfg_write) width_in = pwdata[CFG_WIDTH_W-1:0];
         end
         REG_FRAME_HEIGHT: begin
            prdata = 32'(height_ff);
            if (cfg_write) height_in = pwdata[CFG_HEIGHT_W-1:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // Clamp frame size to the supported range
   assign width_ext = EXT_W'(width_ff);
   always_comb begin
      if (width_ext < EXT_W'(MIN_WIDTH)) begin
         eff_w = WID_W'(MIN_WIDTH);
      end else if (width_ext > EXT_W'(MAX_WIDTH)) begin
         eff_w = WID_W'(MAX_WIDTH);
      end else begin
         eff_w = WID_W'(width_ext);
      end
   end
   assign eff_h = (height_ff == '0) ? CFG_HEIGHT_W'(1) : height_ff;

   // Handshake: stage B drains into the output register
   assign fire_b     = b_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !b_valid_ff || fire_b;
   assign accept     = req_valid && req_ready;
   assign b_valid_in = accept ? 1'b1 : (fire_b ? 1'b0 : b_valid_ff);

   // Position of the incoming request and of the one after it
   assign cur_row = req_payload.frame_start ? '0 : row_ff;
   assign cur_col = req_payload.frame_start ? '0 : col_ff;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (WID_W'(cur_col) >= eff_w - WID_W'(1)) begin
            if (cur_row == ROW_MAX) begin
               row_in = ROW_MAX;
               col_in = COL_W'(eff_w - WID_W'(1));
            end else begin
               row_in = cur_row + ROW_W'(1);
               col_in = '0;
            end
         end else begin
            row_in = cur_row;
            col_in = cur_col + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         b_valid_ff <= b_valid_in;
         if (fire_b && res_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the request in stage B while its RAM words are read
   always_ff @(posedge clock) begin
      if (accept) begin
         b_bit_ff <= req_payload.mask_bit;
         b_row_ff <= cur_row;
         b_col_ff <= cur_col;
      end
      if (fire_b) begin
         rsp_payload_ff.clean_bit  <= res_bit;
         rsp_payload_ff.frame_last <= res_last;
         cls_dly_ff <= {cls_dly_ff[CLOSED_DELAY-2:0], rd_cls_rows[CLOSED_DELAY-1]};
      end
   end

   // Row RAMs, one word per column, newest row in bit 0
   assign wr_in_rows  = {rd_in_rows[SQ_ROWS-2:0], b_bit_ff};
   assign wr_dil_rows = {rd_dil_rows[SQ_ROWS-2:0], dil1};
   assign wr_max_rows = {rd_max_rows[DIL_ROWS-2:0], row_max};
   assign wr_cls_rows = {rd_cls_rows[CLOSED_DELAY-2:0], closed};

   bmm_ram #(.WIDTH(SQ_ROWS), .DEPTH(MAX_WIDTH)) u_input_rows (
      .clock(clock), .we(fire_b), .waddr(b_col_ff), .wdata(wr_in_rows),
      .re(accept), .raddr(cur_col), .rdata(rd_in_rows)
   );

   bmm_ram #(.WIDTH(SQ_ROWS), .DEPTH(MAX_WIDTH)) u_dilated_rows (
      .clock(clock), .we(fire_b), .waddr(b_col_ff), .wdata(wr_dil_rows),
      .re(accept), .raddr(cur_col), .rdata(rd_dil_rows)
   );

   bmm_ram #(.WIDTH(DIL_ROWS), .DEPTH(MAX_WIDTH)) u_row_max_rows (
      .clock(clock), .we(fire_b), .waddr(b_col_ff), .wdata(wr_max_rows),
      .re(accept), .raddr(cur_col), .rdata(rd_max_rows)
   );

   bmm_ram #(.WIDTH(CLOSED_DELAY), .DEPTH(MAX_WIDTH)) u_closed_rows (
      .clock(clock), .we(fire_b), .waddr(b_col_ff), .wdata(wr_cls_rows),
      .re(accept), .raddr(cur_col), .rdata(rd_cls_rows)
   );

   // Rows and columns of the window centers at each stage
   assign r0_s  = SROW_W'(b_row_ff);
   assign h_s   = SROW_W'(eff_h);
   assign c0_x  = CMP_W'(b_col_ff);
   assign w_x   = CMP_W'(eff_w);
   assign c0_lt = (c0_x < CMP_W'(SQ_RADIUS));
   assign c1_x  = c0_lt ? (c0_x + w_x - CMP_W'(SQ_RADIUS)) : (c0_x - CMP_W'(SQ_RADIUS));
   assign c1    = c1_x[COL_W-1:0];
   assign r1_s  = r0_s - SROW_W'(SQ_RADIUS) - SROW_W'(c0_lt);
   assign c1_lt = (c1_x < CMP_W'(DILATE_RADIUS));
   assign c3_x  = c1_lt ? (c1_x + w_x - CMP_W'(DILATE_RADIUS))
                        : (c1_x - CMP_W'(DILATE_RADIUS));
   assign r3_s  = r1_s - SROW_W'(c1_lt);
   assign r4_s  = r3_s - SROW_W'(DILATE_RADIUS);

   // Vertical reductions over in-frame rows
   always_comb begin
      rk_s   = r0_s;
      v1_or  = b_bit_ff & row_in_frame(r0_s, h_s);
      v1_and = b_bit_ff | ~row_in_frame(r0_s, h_s);
      v2_and = dil1 | ~row_in_frame(r1_s, h_s);
      v4_or  = row_max & row_in_frame(r3_s, h_s);
      for (int k = 1; k <= SQ_ROWS; k++) begin
         rk_s   = r0_s - SROW_W'(k);
         v1_or  = v1_or | (rd_in_rows[k-1] & row_in_frame(rk_s, h_s));
         v1_and = v1_and & (rd_in_rows[k-1] | ~row_in_frame(rk_s, h_s));
         rk_s   = r1_s - SROW_W'(k);
         v2_and = v2_and & (rd_dil_rows[k-1] | ~row_in_frame(rk_s, h_s));
      end
      for (int k = 1; k <= DIL_ROWS; k++) begin
         rk_s  = r3_s - SROW_W'(k);
         v4_or = v4_or | (rd_max_rows[k-1] & row_in_frame(rk_s, h_s));
      end
   end

   // Horizontal windows
   bmm_line #(.RADIUS(SQ_RADIUS), .TAKE_MIN(1'b0), .COL_W(COL_W), .WID_W(WID_W)) u_close_dil (
      .clock(clock), .shift_en(fire_b), .din(v1_or), .col(b_col_ff), .frame_w(eff_w),
      .dout(dil1)
   );

   bmm_line #(.RADIUS(SQ_RADIUS), .TAKE_MIN(1'b1), .COL_W(COL_W), .WID_W(WID_W)) u_open_ero (
      .clock(clock), .shift_en(fire_b), .din(v1_and), .col(b_col_ff), .frame_w(eff_w),
      .dout(ero1)
   );

   bmm_line #(.RADIUS(SQ_RADIUS), .TAKE_MIN(1'b1), .COL_W(COL_W), .WID_W(WID_W)) u_close_ero (
      .clock(clock), .shift_en(fire_b), .din(v2_and), .col(c1), .frame_w(eff_w),
      .dout(closed)
   );

   bmm_line #(.RADIUS(DILATE_RADIUS), .TAKE_MIN(1'b0), .COL_W(COL_W), .WID_W(WID_W)) u_row_max (
      .clock(clock), .shift_en(fire_b), .din(ero1), .col(c1), .frame_w(eff_w),
      .dout(row_max)
   );

   // Result for the pixel 32 rows and 32 columns back
   assign res_valid = row_in_frame(r4_s, h_s);
   assign res_last  = (r4_s == h_s - SROW_W'(1)) && (c3_x == w_x - CMP_W'(1));
   assign res_bit   = v4_or & cls_dly_ff[CLOSED_DELAY-1];

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A stalled output with a full stage B blocks new requests
   assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while pipeline is blocked");

   // An accepted request always lands in stage B
   assert property (@(posedge clock) disable iff (reset)
      accept |=> b_valid_ff)
      else $error("accepted request lost before stage B");

   // A new result only appears when stage B advanced
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire_b))
      else $error("result raised without stage B advancing");

   // The frame end marker only comes with an in-frame result
   assert property (@(posedge clock) disable iff (reset)
      (fire_b && res_last) |-> res_valid)
      else $error("frame end flagged outside the frame");

endmodule
